@@ design/sha_pkg.sv @@
// Package for the SHA-256 byte stream hasher: types, constants and round functions.
// Depends on nothing; used by the queue, the engine and the top level.
`timescale 1ns / 1ps
package sha_pkg;
  localparam int unsigned BlockBytes = 64;
  localparam int unsigned QueueDepth = 2;

  typedef enum logic {
    OP_ABSORB = 1'b0,
    OP_FINISH = 1'b1
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [7:0] data;
  } cmd_t;

  localparam logic [31:0] INIT_HASH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] rotr(input logic [31:0] v, input int unsigned s);
    rotr = (v >> s) | (v << (32 - s));
  endfunction
endpackage

@@ design/sha_cmd_queue.sv @@
// Front part of the SHA-256 hasher: a short command queue that accepts items.
// Depends on sha_pkg.
`timescale 1ns / 1ps
module sha_cmd_queue #(
  parameter int unsigned Depth = sha_pkg::QueueDepth
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  sha_pkg::cmd_t in_cmd_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output sha_pkg::cmd_t out_cmd_o
);
  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;

  sha_pkg::cmd_t       mem_q [Depth];
  logic [PtrW-1:0]     wr_q, rd_q;
  logic [PtrW:0]       cnt_q;
  logic                push, pop;

  assign in_ready_o  = (cnt_q != (PtrW+1)'(Depth));
  assign out_valid_o = (cnt_q != '0);
  assign out_cmd_o   = mem_q[rd_q];
  assign push = in_valid_i && in_ready_o;
  assign pop  = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= in_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop) begin
        rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
      end
      cnt_q <= cnt_q + (PtrW+1)'(push) - (PtrW+1)'(pop);
    end
  end
endmodule

@@ design/sha_engine.sv @@
// Back part of the SHA-256 hasher: block buffer, padding, round engine, digest output.
// Depends on sha_pkg.
`timescale 1ns / 1ps
module sha_engine (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_valid_i,
  output logic          cmd_ready_o,
  input  sha_pkg::cmd_t cmd_i,
  output logic          dig_valid_o,
  input  logic          dig_ready_i,
  output logic [31:0]   dig_word_o,
  output logic [2:0]    dig_index_o,
  output logic          dig_last_o
);
  typedef enum logic [2:0] {
    S_IDLE, S_PAD, S_LOAD, S_ROUND, S_ADD, S_EMIT
  } state_e;

  state_e      state_q;
  logic [31:0] h_q [8];
  logic [31:0] v_q [8];
  logic [31:0] w_q [16];
  // The block is held as sixteen big-endian words, byte 0 in the top bits.
  logic [31:0] buf_q [16];
  logic [5:0]  fill_q;
  logic [63:0] bits_q;
  logic [5:0]  rnd_q;
  logic        fin_q;
  logic        extra_q;
  logic [2:0]  idx_q;

  logic [31:0] w_new, t1, t2, s0, s1, ch, mj, g0, g1, w15, w2, w_in;
  logic        cmd_take;
  logic [7:0]  in_byte;
  logic        put_len;
  logic [31:0] pad_word [16];

  assign cmd_ready_o = (state_q == S_IDLE);
  assign cmd_take    = cmd_valid_i && cmd_ready_o;
  assign in_byte     = (cmd_i.op == sha_pkg::OP_ABSORB) ? cmd_i.data : 8'h80;
  assign put_len     = (fill_q < 6'd56) || extra_q;

  // Padded block: bytes after the 0x80 marker are cleared, and the length
  // goes into the last two words when it fits.
  always_comb begin
    for (int i = 0; i < 16; i++) begin
      for (int j = 0; j < 4; j++) begin
        if (!extra_q && (6'(4*i + j) <= fill_q)) begin
          pad_word[i][31-8*j -: 8] = buf_q[i][31-8*j -: 8];
        end else begin
          pad_word[i][31-8*j -: 8] = 8'h00;
        end
      end
    end
    if (put_len) begin
      pad_word[14] = bits_q[63:32];
      pad_word[15] = bits_q[31:0];
    end
  end

  // Schedule word: first sixteen rounds read the buffer big-endian.
  assign w_in = buf_q[rnd_q[3:0]];
  assign w15 = w_q[rnd_q[3:0] + 4'd1];
  assign w2  = w_q[rnd_q[3:0] + 4'd14];
  assign g0  = sha_pkg::rotr(w15, 7) ^ sha_pkg::rotr(w15, 18) ^ (w15 >> 3);
  assign g1  = sha_pkg::rotr(w2, 17) ^ sha_pkg::rotr(w2, 19) ^ (w2 >> 10);
  assign w_new = (rnd_q < 6'd16) ? w_in
               : w_q[rnd_q[3:0]] + g0 + w_q[rnd_q[3:0] + 4'd9] + g1;
  assign s1 = sha_pkg::rotr(v_q[4], 6) ^ sha_pkg::rotr(v_q[4], 11) ^ sha_pkg::rotr(v_q[4], 25);
  assign ch = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
  assign t1 = v_q[7] + s1 + ch + sha_pkg::ROUND_K[rnd_q] + w_new;
  assign s0 = sha_pkg::rotr(v_q[0], 2) ^ sha_pkg::rotr(v_q[0], 13) ^ sha_pkg::rotr(v_q[0], 22);
  assign mj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
  assign t2 = s0 + mj;

  assign dig_valid_o = (state_q == S_EMIT);
  assign dig_word_o  = h_q[idx_q];
  assign dig_index_o = idx_q;
  assign dig_last_o  = (idx_q == 3'd7);

  always_ff @(posedge clk_i) begin
    if (cmd_take) begin
      buf_q[fill_q[5:2]][{~fill_q[1:0], 3'b111} -: 8] <= in_byte;
    end else if (state_q == S_PAD) begin
      for (int i = 0; i < 16; i++) begin
        buf_q[i] <= pad_word[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_LOAD) begin
      for (int i = 0; i < 8; i++) begin
        v_q[i] <= h_q[i];
      end
    end else if (state_q == S_ROUND) begin
      w_q[rnd_q[3:0]] <= w_new;
      for (int i = 1; i < 8; i++) begin
        if (i == 4) begin
          v_q[i] <= v_q[3] + t1;
        end else begin
          v_q[i] <= v_q[i-1];
        end
      end
      v_q[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      for (int i = 0; i < 8; i++) begin
        h_q[i] <= sha_pkg::INIT_HASH[i];
      end
      fill_q  <= '0;
      bits_q  <= '0;
      rnd_q   <= '0;
      fin_q   <= 1'b0;
      extra_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (cmd_take) begin
            if (cmd_i.op == sha_pkg::OP_ABSORB) begin
              fill_q <= fill_q + 6'd1;
              bits_q <= bits_q + 64'd8;
              if (fill_q == 6'd63) begin
                fin_q   <= 1'b0;
                state_q <= S_LOAD;
              end
            end else begin
              fin_q   <= 1'b1;
              extra_q <= 1'b0;
              state_q <= S_PAD;
            end
          end
        end
        S_PAD: begin
          // A first padded block is extra when the length no longer fits.
          if (!extra_q && fill_q >= 6'd56) begin
            extra_q <= 1'b1;
          end else begin
            extra_q <= 1'b0;
          end
          state_q <= S_LOAD;
        end
        S_LOAD: begin
          rnd_q   <= '0;
          state_q <= S_ROUND;
        end
        S_ROUND: begin
          rnd_q <= rnd_q + 6'd1;
          if (rnd_q == 6'd63) begin
            state_q <= S_ADD;
          end
        end
        S_ADD: begin
          for (int i = 0; i < 8; i++) begin
            h_q[i] <= h_q[i] + v_q[i];
          end
          fill_q <= '0;
          if (!fin_q) begin
            state_q <= S_IDLE;
          end else if (extra_q) begin
            state_q <= S_PAD;
          end else begin
            idx_q   <= '0;
            state_q <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (dig_ready_i) begin
            idx_q <= idx_q + 3'd1;
            if (idx_q == 3'd7) begin
              for (int i = 0; i < 8; i++) begin
                h_q[i] <= sha_pkg::INIT_HASH[i];
              end
              fill_q  <= '0;
              bits_q  <= '0;
              fin_q   <= 1'b0;
              state_q <= S_IDLE;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule

@@ design/sha256_byte_stream_hasher_core.sv @@
// Top level of the SHA-256 byte stream hasher: command queue plus engine.
// Depends on sha_pkg, sha_cmd_queue and sha_engine.
`timescale 1ns / 1ps
//
//  Channel   Direction  Payload
//  s_axis    in         tdata[7:0] data_byte, tuser[0] operation
//  m_axis    out        tdata[31:0] digest_word, tuser[2:0] word_index, tlast last_word
//
// An absorb transfer is taken by the engine while it is idle, and every 64th one
// adds a compression (load, 64 rounds of the single round unit, add). A finish
// runs one or two compressions, each after a padding step, and then eight output
// transfers. Reset sets the initial hash value; there is no clearing pass. The
// two-entry queue keeps taking transfers until it is full while the engine
// compresses or the digest is stalled.
module sha256_byte_stream_hasher_core #(
  parameter int unsigned QueueDepth = sha_pkg::QueueDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tuser,   // [0] operation
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] digest_word
  output logic [2:0]  m_axis_tuser,   // [2:0] word_index
  output logic        m_axis_tlast
);
  sha_pkg::cmd_t in_cmd, q_cmd;
  logic          q_valid, q_ready;

  assign in_cmd.op   = sha_pkg::op_e'(s_axis_tuser);
  assign in_cmd.data = s_axis_tdata;

  sha_cmd_queue #(.Depth(QueueDepth)) u_queue (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready), .in_cmd_i(in_cmd),
    .out_valid_o(q_valid), .out_ready_i(q_ready), .out_cmd_o(q_cmd)
  );

  sha_engine u_engine (
    .clk_i, .rst_ni,
    .cmd_valid_i(q_valid), .cmd_ready_o(q_ready), .cmd_i(q_cmd),
    .dig_valid_o(m_axis_tvalid), .dig_ready_i(m_axis_tready),
    .dig_word_o(m_axis_tdata), .dig_index_o(m_axis_tuser), .dig_last_o(m_axis_tlast)
  );
endmodule

@@ design/sha_checker.sv @@
// Port checker for the SHA-256 hasher, bound to the top level.
// Depends on sha256_byte_stream_hasher_core.
`timescale 1ns / 1ps
module sha_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic [2:0]  m_axis_tuser,
  input logic        m_axis_tlast
);
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser == 3'd7)))
    else $error("tlast does not match word index");
  a_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=>
      (m_axis_tvalid && m_axis_tuser == $past(m_axis_tuser) + 3'd1))
    else $error("digest words not consecutive");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
    else $error("stalled digest word changed");
  a_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> !m_axis_tvalid)
    else $error("output after last word");
endmodule

bind sha256_byte_stream_hasher_core sha_checker u_sha_checker (.*);
